@@ hdl/metadata_page_table_fill_unit_assert.svh @@
// Assertion macros shared by the metadata page table fill unit.
// Depends on nothing; included by the modules that carry assertions.
`ifndef METADATA_PAGE_TABLE_FILL_UNIT_ASSERT_SVH
`define METADATA_PAGE_TABLE_FILL_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPTF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mptf assertion failed");

// Next-cycle implication, checked outside reset.
`define MPTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mptf assertion failed");

`endif

@@ hdl/mptf_pkg.sv @@
// Package of the metadata page table fill unit: field widths, status codes,
// default parameter values. Depends on nothing.
package mptf_pkg;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned BytesW = 25;
  localparam int unsigned PtrW   = 48;
  localparam int unsigned AlignW = 6;
  localparam int unsigned MbpuW  = 7;
  localparam int unsigned EntryW = 64;
  localparam int unsigned StatW  = 2;

  localparam int unsigned PageBytesDef    = 4096;
  localparam int unsigned TableEntriesDef = 4096;

  localparam logic [MbpuW-1:0] MbpuReset = 7'd8;

  localparam logic [StatW-1:0] StatusOk    = 2'd0;
  localparam logic [StatW-1:0] StatusSize  = 2'd1;
  localparam logic [StatW-1:0] StatusRange = 2'd2;

  localparam logic CmdSet = 1'b0;
  localparam logic CmdGet = 1'b1;

endpackage

@@ hdl/mptf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mptf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/mptf_entry_unit.sv @@
// Shared entry arithmetic: shift, multiply by bytes per unit (registered), then
// add the metadata pointer and pack the entry. Depends on mptf_pkg.
module mptf_entry_unit #(
  parameter int unsigned IdxW      = 12,
  parameter int unsigned PageShift = 12
) (
  input  logic                        clk_i,
  input  logic                        calc_i,
  input  logic [IdxW-1:0]             idx_i,
  input  logic [mptf_pkg::AlignW-1:0] align_i,
  input  logic [mptf_pkg::MbpuW-1:0]  mbpu_i,
  input  logic [mptf_pkg::PtrW-1:0]   ptr_i,
  output logic [mptf_pkg::EntryW-1:0] entry_o
);
  import mptf_pkg::*;

  localparam int unsigned ShW   = IdxW + PageShift;
  localparam int unsigned ProdW = ShW + MbpuW;

  logic [ShW-1:0]    shifted;
  logic [ProdW-1:0]  prod_q;
  logic [EntryW-1:0] base;

  // Byte offset of page i, scaled down to alignment units.
  assign shifted = {idx_i, {PageShift{1'b0}}} >> align_i;

  always_ff @(posedge clk_i) begin
    if (calc_i) begin
      prod_q <= ProdW'(shifted) * ProdW'(mbpu_i);
    end
  end

  always_comb begin
    if (ptr_i == '0) begin
      base = '0;
    end else begin
      base = EntryW'(ptr_i) + EntryW'(prod_q);
    end
  end

  // The shift by eight drops the top byte of the sum.
  assign entry_o = {base[EntryW-9:0], 2'b00, align_i};

endmodule

@@ hdl/metadata_page_table_fill_unit.sv @@
// Top level of the metadata page table fill unit: command decode, sequencer,
// result registers. Depends on mptf_pkg, mptf_ram, mptf_entry_unit and the assert header.
//
// The block holds one 64-bit metadata entry per page in an on-chip RAM. After
// reset it runs a clearing pass that writes zero to every entry, one entry per
// cycle, and busy stays high, so no command is taken, until all TableEntries
// entries (4096 by default) are cleared; configuration writes are taken meanwhile.
// A command is taken when start is high and busy is low. A get passes its
// entry through the RAM's registered read port and then the result register.
// A set that fails its size or range check, or covers no pages, gives its
// status in the cycle after the command. A good set writes its pages one by
// one through a single shift-multiply-add unit, per page a calc state for the
// multiply and a write state for the add and RAM write, and its result comes
// after the last write. Each command produces exactly one result, shown
// on status_o and entry_o for one cycle while done_o is high. The receiver
// cannot stall: it must capture the result in that cycle. The bytes-per-unit
// register is written through the cfg channel, whose ready is always high,
// and must only be changed while no command is in progress.
module metadata_page_table_fill_unit #(
  parameter int unsigned PageBytes    = mptf_pkg::PageBytesDef,
  parameter int unsigned TableEntries = mptf_pkg::TableEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command_i,
  input  logic [mptf_pkg::AddrW-1:0]  address_i,
  input  logic [mptf_pkg::BytesW-1:0] range_bytes_i,
  input  logic [mptf_pkg::PtrW-1:0]   meta_pointer_i,
  input  logic [mptf_pkg::AlignW-1:0] align_shift_i,
  output logic                        done_o,
  output logic [mptf_pkg::StatW-1:0]  status_o,
  output logic [mptf_pkg::EntryW-1:0] entry_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mptf_pkg::MbpuW-1:0]  cfg_data_i
);
  import mptf_pkg::*;
  `include "metadata_page_table_fill_unit_assert.svh"

  // PageBytes is a power of two.
  localparam int unsigned PageShift = $clog2(PageBytes);
  localparam int unsigned IdxW      = $clog2(TableEntries);
  localparam int unsigned CntW      = $clog2(TableEntries + 1);
  localparam int unsigned PageW     = AddrW - PageShift;
  localparam int unsigned CountW    = BytesW - PageShift;
  localparam int unsigned ChkW      = AddrW + 1;

  typedef enum logic [4:0] {
    StClear = 5'b00001,
    StIdle  = 5'b00010,
    StRead  = 5'b00100,
    StCalc  = 5'b01000,
    StWrite = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [MbpuW-1:0]  mbpu_q;
  logic [IdxW-1:0]   wr_addr_q, wr_addr_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [PtrW-1:0]   ptr_q, ptr_d;
  logic [AlignW-1:0] align_q, align_d;
  logic              done_q, done_d;
  logic [StatW-1:0]  status_q, status_d;
  logic [EntryW-1:0] entry_q, entry_d;

  logic              accept;
  logic [PageW-1:0]  page_full;
  logic [CountW-1:0] count_full;
  logic              get_oob;
  logic              size_err;
  logic              range_err;

  logic              ram_we;
  logic [EntryW-1:0] ram_wdata;
  logic              ram_re;
  logic [EntryW-1:0] ram_rdata;
  logic              calc;
  logic [EntryW-1:0] calc_entry;

  assign accept      = start && !busy;
  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  // Command checks are done in the cycle the request is taken.
  assign page_full  = address_i[AddrW-1:PageShift];
  assign count_full = range_bytes_i[BytesW-1:PageShift];
  assign get_oob    = ChkW'(page_full) >= ChkW'(TableEntries);
  assign size_err   = range_bytes_i[PageShift-1:0] != '0;
  // A start page beyond the table already makes the sum exceed it.
  assign range_err  = (ChkW'(page_full) + ChkW'(count_full)) > ChkW'(TableEntries);

  assign ram_re = accept && (command_i == CmdGet) && !get_oob;
  assign calc   = (state_q == StCalc);

  always_comb begin
    state_d   = state_q;
    wr_addr_d = wr_addr_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    ptr_d     = ptr_q;
    align_d   = align_q;
    done_d    = 1'b0;
    status_d  = status_q;
    entry_d   = entry_q;
    ram_we    = 1'b0;
    ram_wdata = calc_entry;

    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        wr_addr_d = wr_addr_q + 1'b1;
        if (wr_addr_q == IdxW'(TableEntries - 1)) begin
          wr_addr_d = '0;
          state_d   = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          entry_d  = '0;
          status_d = StatusOk;
          if (command_i == CmdGet) begin
            if (get_oob) begin
              status_d = StatusRange;
              done_d   = 1'b1;
            end else begin
              state_d = StRead;
            end
          end else if (size_err) begin
            status_d = StatusSize;
            done_d   = 1'b1;
          end else if (range_err) begin
            status_d = StatusRange;
            done_d   = 1'b1;
          end else if (count_full == '0) begin
            done_d = 1'b1;
          end else begin
            wr_addr_d = page_full[IdxW-1:0];
            idx_d     = '0;
            rem_d     = CntW'(count_full);
            ptr_d     = meta_pointer_i;
            align_d   = align_shift_i;
            state_d   = StCalc;
          end
        end
      end
      StRead: begin
        entry_d = ram_rdata;
        done_d  = 1'b1;
        state_d = StIdle;
      end
      StCalc: begin
        state_d = StWrite;
      end
      StWrite: begin
        ram_we = 1'b1;
        if (rem_q == CntW'(1)) begin
          done_d  = 1'b1;
          state_d = StIdle;
        end else begin
          rem_d     = rem_q - 1'b1;
          idx_d     = idx_q + 1'b1;
          wr_addr_d = wr_addr_q + 1'b1;
          state_d   = StCalc;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      wr_addr_q <= '0;
      done_q    <= 1'b0;
      mbpu_q    <= MbpuReset;
    end else begin
      state_q   <= state_d;
      wr_addr_q <= wr_addr_d;
      done_q    <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mbpu_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    rem_q    <= rem_d;
    ptr_q    <= ptr_d;
    align_q  <= align_d;
    status_q <= status_d;
    entry_q  <= entry_d;
  end

  mptf_ram #(
    .Width (EntryW),
    .Depth (TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (page_full[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  mptf_entry_unit #(
    .IdxW      (IdxW),
    .PageShift (PageShift)
  ) u_entry (
    .clk_i   (clk_i),
    .calc_i  (calc),
    .idx_i   (idx_q),
    .align_i (align_q),
    .mbpu_i  (mbpu_q),
    .ptr_i   (ptr_q),
    .entry_o (calc_entry)
  );

  assign done_o   = done_q;
  assign status_o = status_q;
  assign entry_o  = entry_q;

  `MPTF_ASSERT_NOW(a_we_states, clk_i, rst_ni, ram_we, (state_q == StClear || state_q == StWrite))
  `MPTF_ASSERT_NEXT(a_read_done, clk_i, rst_ni, state_q == StRead, done_q && status_q == StatusOk)
  `MPTF_ASSERT_NEXT(a_get_oob, clk_i, rst_ni, accept && command_i == CmdGet && get_oob, done_q && status_q == StatusRange && entry_q == '0)
  `MPTF_ASSERT_NEXT(a_fill_end, clk_i, rst_ni, state_q == StWrite && rem_q == CntW'(1), done_q && status_q == StatusOk && state_q == StIdle)
  `MPTF_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_q, state_q == StIdle)

endmodule
